/* rtl/rpdu_pkg.sv */
`timescale 1ns / 1ps
// shared constants, field widths and types of the radix digit unpacker
// no dependencies; compile first

package rpdu_pkg;

    localparam int WORD_BITS_DEF  = 32;
    localparam int COUNT_BITS_DEF = 16;

    // payload field widths
    localparam int RADIX_W  = 5;
    localparam int DPW_W    = 5;
    localparam int SAMPLE_W = 16;
    localparam int DIGIT_W  = 5;

    // most digits one word can yield (limit of the 5-bit digits_per_word field)
    localparam int MAX_DIGITS = 31;

    // dividend bits the back end retires per cycle
    localparam int CHUNK_BITS = 8;

    // entries of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // per-word job description handed from front to back
    typedef struct packed {
        logic [RADIX_W-1:0] base;
        logic [DPW_W-1:0]   n_digits;
        logic               end_vec;
    } t_job_ctl;

    localparam int JOB_CTL_W = $bits(t_job_ctl);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_EMIT = 3'b100
    } t_back_state;

endpackage

/* rtl/rpdu_if.sv */
`timescale 1ns / 1ps
// valid/ready channel interfaces for packed words in and digits out
// depends on rpdu_pkg

interface rpdu_in_if #(
    parameter int WORD_BITS = rpdu_pkg::WORD_BITS_DEF
);
    import rpdu_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [WORD_BITS-1:0] packed_word;
    logic [RADIX_W-1:0]   radix;
    logic [DPW_W-1:0]     digits_per_word;
    logic [SAMPLE_W-1:0]  sample_count;
    logic                 first_word;

    modport source (
        output valid, packed_word, radix, digits_per_word, sample_count, first_word,
        input  ready
    );
    modport sink (
        input  valid, packed_word, radix, digits_per_word, sample_count, first_word,
        output ready
    );
endinterface

interface rpdu_out_if;
    import rpdu_pkg::*;

    logic               valid;
    logic               ready;
    logic [DIGIT_W-1:0] digit;
    logic               last_of_word;
    logic               last_of_vector;

    modport source (
        output valid, digit, last_of_word, last_of_vector,
        input  ready
    );
    modport sink (
        input  valid, digit, last_of_word, last_of_vector,
        output ready
    );
endinterface

/* rtl/radix_packed_digit_unpacker_unit.sv */
`timescale 1ns / 1ps
// digits: the digits of a word come one after another from the shared divider that retires
//   8 dividend bits per cycle; the back end works on one word at a time while the queue
//   takes further words, and words that yield nothing never reach the back end
// reset: synchronous active low; clears the count, marks no vector active, empties the queue
// top level of the radix digit unpacker; depends on rpdu_pkg, rpdu_if, front, queue and back

module radix_packed_digit_unpacker_unit #(
    parameter int WORD_BITS  = rpdu_pkg::WORD_BITS_DEF,
    parameter int COUNT_BITS = rpdu_pkg::COUNT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rpdu_in_if.sink     i_in,
    rpdu_out_if.source  o_out
);
    import rpdu_pkg::*;

    // one queue entry: the word plus its job description
    localparam int JOB_W = WORD_BITS + JOB_CTL_W;

    logic                 push, full, q_valid, pop;
    logic [WORD_BITS-1:0] f_word;
    t_job_ctl             f_ctl, b_ctl;
    logic [JOB_W-1:0]     q_in, q_out;

    // front: handles first_word and the vector count, decides how many digits
    // each word yields and whether it closes the vector; words that yield
    // nothing never reach the queue
    rpdu_front #(
        .WORD_BITS  (WORD_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_word  (f_word),
        .o_ctl   (f_ctl)
    );

    assign q_in = {f_word, f_ctl};

    // decouples word acceptance from the long-running digit extraction
    rpdu_queue #(
        .WIDTH (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_in),
        .o_full  (full),
        .o_valid (q_valid),
        .o_data  (q_out),
        .i_pop   (pop)
    );

    assign b_ctl = t_job_ctl'(q_out[JOB_CTL_W-1:0]);

    // back: repeated divide by radix, remainder out as the digit, registered
    // output beat so the next division runs while a digit waits
    rpdu_back #(
        .WORD_BITS (WORD_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_word  (q_out[JOB_W-1:JOB_CTL_W]),
        .i_ctl   (b_ctl),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

/* rtl/rpdu_front.sv */
`timescale 1ns / 1ps
// front end: accepts words, tracks the vector count and sizes each word's job
// depends on rpdu_pkg and rpdu_in_if

module rpdu_front #(
    parameter int WORD_BITS  = rpdu_pkg::WORD_BITS_DEF,
    parameter int COUNT_BITS = rpdu_pkg::COUNT_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    rpdu_in_if.sink              i_in,
    input  logic                 i_full,
    output logic                 o_push,
    output logic [WORD_BITS-1:0] o_word,
    output rpdu_pkg::t_job_ctl   o_ctl
);
    import rpdu_pkg::*;

    localparam int CMP_W = (COUNT_BITS > SAMPLE_W) ? COUNT_BITS : SAMPLE_W;

    logic [COUNT_BITS-1:0] r_count, n_count, eff_count;
    logic                  r_done, n_done, eff_done;
    logic                  accept;
    logic [MAX_DIGITS-1:0] hit;
    logic [DPW_W-1:0]      n_dig;
    logic                  any_hit;
    logic [RADIX_W-1:0]    base;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;

    // first word restarts the vector
    assign eff_count = i_in.first_word ? '0 : r_count;
    assign eff_done  = i_in.first_word ? 1'b0 : r_done;

    // radix zero behaves as radix one
    assign base = (i_in.radix < RADIX_W'(2)) ? RADIX_W'(1) : i_in.radix;

    // digit j ends the vector when the wrapped count after it reaches the target
    always_comb begin
        for (int j = 0; j < MAX_DIGITS; j++) begin
            hit[j] = (CMP_W'(COUNT_BITS'(eff_count + COUNT_BITS'(j + 1)))
                      >= CMP_W'(i_in.sample_count))
                     && (DPW_W'(j) < i_in.digits_per_word);
        end
    end

    // earliest ending digit wins
    always_comb begin
        n_dig = i_in.digits_per_word;
        for (int j = MAX_DIGITS - 1; j >= 0; j--) begin
            if (hit[j]) begin
                n_dig = DPW_W'(j + 1);
            end
        end
    end

    assign any_hit = |hit;

    assign o_push         = accept && !eff_done && (i_in.digits_per_word != '0);
    assign o_word         = i_in.packed_word;
    assign o_ctl.base     = base;
    assign o_ctl.n_digits = n_dig;
    assign o_ctl.end_vec  = any_hit;

    always_comb begin
        n_count = r_count;
        n_done  = r_done;
        if (accept) begin
            n_count = eff_count;
            n_done  = eff_done;
            if (o_push) begin
                n_count = COUNT_BITS'(eff_count + COUNT_BITS'(n_dig));
                n_done  = any_hit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b1;
        end else begin
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

`ifndef ASSERT_OFF
    a_job_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (o_ctl.n_digits != '0) && (o_ctl.n_digits <= i_in.digits_per_word))
        else $error("job digit count out of range");

    a_full_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && !o_ctl.end_vec |-> o_ctl.n_digits == i_in.digits_per_word)
        else $error("open vector job shorter than the word");

    a_done_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_done) |-> $past(o_push && o_ctl.end_vec))
        else $error("vector closed without an ending job");
`endif

endmodule

/* rtl/rpdu_queue.sv */
`timescale 1ns / 1ps
// short first-in first-out job queue between front and back
// depends on rpdu_pkg for the default depth

module rpdu_queue #(
    parameter int WIDTH = 1,
    parameter int DEPTH = rpdu_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data,
    input  logic             i_pop
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr, r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(r_wr + PTR_W'(1));
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(r_rd + PTR_W'(1));
        end
        if (do_push && !do_pop) begin
            n_cnt = CNT_W'(r_cnt + CNT_W'(1));
        end else if (do_pop && !do_push) begin
            n_cnt = CNT_W'(r_cnt - CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into a full job queue");

    a_full_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> o_valid)
        else $error("full job queue reports no data");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(DEPTH))
        else $error("job queue count above depth");
`endif

endmodule

/* rtl/rpdu_back.sv */
`timescale 1ns / 1ps
// back end: iterative divide by radix, one digit per division, output register
// depends on rpdu_pkg and rpdu_out_if

module rpdu_back #(
    parameter int WORD_BITS = rpdu_pkg::WORD_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [WORD_BITS-1:0] i_word,
    input  rpdu_pkg::t_job_ctl   i_ctl,
    output logic                 o_pop,
    rpdu_out_if.source           o_out
);
    import rpdu_pkg::*;

    localparam int STEPS  = (WORD_BITS + CHUNK_BITS - 1) / CHUNK_BITS;
    localparam int PAD_W  = STEPS * CHUNK_BITS;
    localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;

    t_back_state          r_state, n_state;
    logic [PAD_W-1:0]     r_wsh, n_wsh, r_quo, n_quo;
    logic [RADIX_W-1:0]   r_rem, n_rem, r_base, n_base;
    logic [DPW_W-1:0]     r_left, n_left;
    logic                 r_end, n_end;
    logic [STEP_W-1:0]    r_step, n_step;
    logic                 r_out_valid, n_out_valid;
    logic [DIGIT_W-1:0]   r_out_digit, n_out_digit;
    logic                 r_out_low, n_out_low, r_out_lov, n_out_lov;

    logic                 out_free;
    logic [RADIX_W-1:0]   rem_w;
    logic [RADIX_W:0]     trial;
    logic [CHUNK_BITS-1:0] q_chunk;

    assign out_free = !r_out_valid || o_out.ready;
    assign o_pop    = (r_state == ST_IDLE);

    // restoring long division of the top chunk, one bit per step
    always_comb begin
        rem_w   = r_rem;
        q_chunk = '0;
        trial   = '0;
        for (int b = CHUNK_BITS - 1; b >= 0; b--) begin
            trial = {rem_w, r_wsh[PAD_W - CHUNK_BITS + b]};
            if (trial >= {1'b0, r_base}) begin
                q_chunk[b] = 1'b1;
                rem_w      = RADIX_W'(trial - {1'b0, r_base});
            end else begin
                rem_w = RADIX_W'(trial);
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_wsh       = r_wsh;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_base      = r_base;
        n_left      = r_left;
        n_end       = r_end;
        n_step      = r_step;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_digit = r_out_digit;
        n_out_low   = r_out_low;
        n_out_lov   = r_out_lov;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_wsh   = PAD_W'(i_word);
                    n_base  = i_ctl.base;
                    n_left  = i_ctl.n_digits;
                    n_end   = i_ctl.end_vec;
                    n_rem   = '0;
                    n_step  = '0;
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                n_wsh  = r_wsh << CHUNK_BITS;
                n_quo  = (r_quo << CHUNK_BITS) | PAD_W'(q_chunk);
                n_rem  = rem_w;
                n_step = STEP_W'(r_step + STEP_W'(1));
                if (r_step == STEP_W'(STEPS - 1)) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_digit = DIGIT_W'(r_rem);
                    n_out_low   = (r_left == DPW_W'(1));
                    n_out_lov   = r_end && (r_left == DPW_W'(1));
                    if (r_left == DPW_W'(1)) begin
                        n_state = ST_IDLE;
                    end else begin
                        // quotient becomes the dividend of the next digit
                        n_wsh   = r_quo;
                        n_rem   = '0;
                        n_step  = '0;
                        n_left  = DPW_W'(r_left - DPW_W'(1));
                        n_state = ST_DIV;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wsh       <= n_wsh;
        r_quo       <= n_quo;
        r_rem       <= n_rem;
        r_base      <= n_base;
        r_left      <= n_left;
        r_end       <= n_end;
        r_step      <= n_step;
        r_out_digit <= n_out_digit;
        r_out_low   <= n_out_low;
        r_out_lov   <= n_out_lov;
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.digit          = r_out_digit;
    assign o_out.last_of_word   = r_out_low;
    assign o_out.last_of_vector = r_out_lov;

`ifndef ASSERT_OFF
    a_busy_has_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ST_IDLE |-> r_left != '0)
        else $error("back end busy with no digits left");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DIV |-> r_rem < r_base)
        else $error("partial remainder not below radix");

    a_vec_ends_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.last_of_vector |-> o_out.last_of_word)
        else $error("vector end not flagged as word end");
`endif

endmodule

/* dv/radix_packed_digit_unpacker_unit_tb.sv */
`timescale 1ns / 1ps
// self-checking bench for the radix digit unpacker: drives packed words, predicts every digit
// depends on rpdu_pkg, rpdu_if and the radix_packed_digit_unpacker_unit rtl

module radix_packed_digit_unpacker_unit_tb;
    import rpdu_pkg::*;

    localparam int WORD_BITS    = WORD_BITS_DEF;
    localparam int COUNT_BITS   = COUNT_BITS_DEF;
    localparam int RAND_WORDS   = 140;
    localparam int CALM_WORDS   = 30;    // tail of the run without idling
    localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
    localparam int STALL_LIMIT  = 4000;  // cycles without any beat before giving up
    localparam int DRAIN_CYCLES = 200;

    // one packed word beat as offered to the block
    typedef struct packed {
        logic [WORD_BITS-1:0] word;
        logic [RADIX_W-1:0]   radix;
        logic [DPW_W-1:0]     digits_per_word;
        logic [SAMPLE_W-1:0]  sample_count;
        logic                 first_word;
    } t_word_beat;

    // one digit beat as produced by the block
    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic               last_of_word;
        logic               last_of_vector;
    } t_digit_beat;

    // digit predictor plus queue of digits still owed by the block
    class digit_scoreboard;
        logic [COUNT_BITS-1:0] emitted_count;
        bit                    vector_done;
        t_digit_beat           owed_digits[$];
        int                    errors;
        int                    words_in;
        int                    digits_out;
        int                    vectors_started;

        function new();
            emitted_count   = '0;
            vector_done     = 1'b1;
            errors          = 0;
            words_in        = 0;
            digits_out      = 0;
            vectors_started = 0;
        endfunction

        task report(string what, int got, int want);
            errors++;
            $display("mismatch at digit %0d: %s got %0d want %0d", digits_out, what, got, want);
        endtask

        // divide the word down, one digit per step, until the word or the vector runs out
        function void note_word(t_word_beat w);
            logic [WORD_BITS-1:0] rest;
            logic [WORD_BITS-1:0] base;
            t_digit_beat          d;
            bit                   end_vec;
            words_in++;
            if (w.first_word) begin
                emitted_count = '0;
                vector_done   = 1'b0;
                vectors_started++;
            end
            if (vector_done) return;
            // radix zero behaves as radix one: every digit is zero
            base = (w.radix < 2) ? 1 : WORD_BITS'(w.radix);
            rest = w.word;
            for (int j = 0; j < int'(w.digits_per_word); j++) begin
                d.digit = DIGIT_W'(rest % base);
                rest = rest / base;
                emitted_count = emitted_count + 1'b1;
                end_vec = (emitted_count >= w.sample_count);
                d.last_of_word   = end_vec || (j + 1 == int'(w.digits_per_word));
                d.last_of_vector = end_vec;
                owed_digits = {owed_digits, d};
                if (end_vec) begin
                    vector_done = 1'b1;
                    break;
                end
            end
        endfunction

        task check_digit(t_digit_beat got);
            t_digit_beat want;
            if (owed_digits.size() == 0) begin
                report("digit with none owed, value", got.digit, -1);
            end else begin
                want = owed_digits.pop_front();
                if (got.digit !== want.digit)
                    report("digit", got.digit, want.digit);
                if (got.last_of_word !== want.last_of_word)
                    report("last_of_word", got.last_of_word, want.last_of_word);
                if (got.last_of_vector !== want.last_of_vector)
                    report("last_of_vector", got.last_of_vector, want.last_of_vector);
            end
            digits_out++;
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    rpdu_in_if #(.WORD_BITS(WORD_BITS)) in_if ();
    rpdu_out_if                         out_if ();

    radix_packed_digit_unpacker_unit #(
        .WORD_BITS (WORD_BITS),
        .COUNT_BITS(COUNT_BITS)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    digit_scoreboard sb = new();

    bit idle_on  = 1'b1;   // random idling on both sides
    bit hold_req = 1'b0;   // asks the digit sink for one long hold-off
    int quiet_cycles = 0;

    // 12 ns clock
    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // every input known from time zero
    initial begin
        i_rst_n               = 1'b0;
        in_if.valid           = 1'b0;
        in_if.packed_word     = '0;
        in_if.radix           = '0;
        in_if.digits_per_word = '0;
        in_if.sample_count    = '0;
        in_if.first_word      = 1'b0;
        out_if.ready          = 1'b0;
    end

    // offer one word beat, with an optional idle burst first, and wait for its acceptance
    task automatic send_word(input logic [WORD_BITS-1:0] word, input int radix, input int dpw,
                             input int sample, input bit first);
        t_word_beat w;
        int         gap;
        w.word            = word;
        w.radix           = RADIX_W'(radix);
        w.digits_per_word = DPW_W'(dpw);
        w.sample_count    = SAMPLE_W'(sample);
        w.first_word      = first;
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 13);
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid           <= 1'b1;
        in_if.packed_word     <= w.word;
        in_if.radix           <= w.radix;
        in_if.digits_per_word <= w.digits_per_word;
        in_if.sample_count    <= w.sample_count;
        in_if.first_word      <= w.first_word;
        do @(posedge i_clk); while (!in_if.ready);
        sb.note_word(w);
    endtask

    // well-formed vector: same radix and digit count on every word, first flag on word one
    task automatic send_vector(input int radix, input int dpw, input int sample, input int words);
        for (int k = 0; k < words; k++)
            send_word($urandom, radix, dpw, sample, k == 0);
    endtask

    // digit sink: random stall bursts, one long hold-off on request, none in the calm tail
    initial begin : digit_sink
        int burst;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                out_if.ready <= 1'b0;
                burst = $urandom_range(1, 13);
                repeat (burst - 1) @(negedge i_clk);
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // digit monitor and watchdog, sampled at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready)
                sb.check_digit({out_if.digit, out_if.last_of_word, out_if.last_of_vector});
            if ((out_if.valid && out_if.ready) || (in_if.valid && in_if.ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= STALL_LIMIT) begin
                $display("timeout after %0d cycles without a beat", quiet_cycles);
                $display("radix_packed_digit_unpacker_unit_tb: done, errors");
                $finish;
            end else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int rand_words;
        int kind;
        int radix;
        int dpw;
        int sample;
        int words;
        bit hold_done;
        rand_words = 0;
        hold_done  = 1'b0;

        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed part
        // nothing active after reset: word yields no digits
        send_word(32'h1234_5678, 10, 3, 5, 1'b0);
        // radix two, widest word, largest count: 31 ones then 31 zeros
        send_word(32'hFFFF_FFFF, 2, 31, 65535, 1'b1);
        send_word(32'h0000_0000, 2, 31, 65535, 1'b0);
        // radix nineteen, vector ends mid-word, then a word after completion
        send_word(32'hFFFF_FFFF, 19, 7, 10, 1'b1);
        send_word(32'hA5A5_5A5A, 19, 7, 10, 1'b0);
        send_word(32'hFFFF_FFFF, 19, 7, 10, 1'b0);
        // radix zero and one give all-zero digits
        send_word(32'hFFFF_FFFF, 0, 4, 3, 1'b1);
        send_word(32'hFFFF_FFFF, 1, 2, 100, 1'b1);
        // zero digits per word leaves the count alone
        send_word(32'h8000_0001, 1, 0, 100, 1'b0);
        send_word(32'h8000_0001, 3, 2, 100, 1'b0);
        // first word with zero digits still re-arms the vector
        send_word(32'h0000_0007, 3, 0, 2, 1'b1);
        send_word(32'h0000_0007, 3, 5, 2, 1'b0);
        // zero sample count: exactly one digit, closing the vector
        send_word(32'h0000_0123, 10, 5, 0, 1'b1);
        send_word(32'h0000_0123, 10, 5, 0, 1'b0);
        // radix above nineteen, up to the widest field value
        send_word(32'hDEAD_BEEF, 31, 6, 40, 1'b1);
        send_word(32'hDEAD_BEEF, 20, 6, 40, 1'b0);
        // new vector cut in before the old one finished
        send_word(32'h0000_0000, 19, 1, 1, 1'b1);
        send_word(32'h7FFF_FFFF, 5, 3, 50, 1'b1);
        send_word(32'h0F0F_F0F0, 5, 3, 2, 1'b1);
        send_word(32'h0F0F_F0F0, 16, 8, 32768, 1'b1);

        // random part: mostly whole vectors, some cut short, some raw noise
        while (rand_words < RAND_WORDS) begin
            if (rand_words >= RAND_WORDS - CALM_WORDS)
                idle_on = 1'b0;
            // hold the sink off once while words keep coming, so the block backs up
            if (!hold_done && rand_words >= 20) begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            kind = $urandom_range(0, 9);
            if (kind <= 7) begin
                radix  = $urandom_range(2, 19);
                dpw    = $urandom_range(1, 31);
                sample = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 200)
                                                     : $urandom_range(1, 60);
                words  = (sample + dpw - 1) / dpw;
                if (words > 10) begin
                    words  = 10;
                    sample = dpw * 10 - $urandom_range(0, dpw - 1);
                end
                if (kind == 7)
                    words = $urandom_range(1, words);  // broken off early
                else if ($urandom_range(0, 3) == 0)
                    words++;                            // trailing word after completion
                send_vector(radix, dpw, sample, words);
                rand_words += words;
            end else begin
                send_word($urandom, $urandom_range(0, 31), $urandom_range(0, 31),
                          $urandom_range(0, 65535), $urandom_range(0, 1));
                rand_words++;
            end
        end

        @(negedge i_clk);
        in_if.valid <= 1'b0;

        // let the block finish owed digits, then watch for strays
        while (sb.owed_digits.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d words in %0d vectors, %0d digits checked, with stalls and a hold-off",
                 sb.words_in, sb.vectors_started, sb.digits_out);
        $display("mismatches counted: %0d", sb.errors);
        if (sb.errors == 0)
            $display("radix_packed_digit_unpacker_unit_tb: done, clean");
        else
            $display("radix_packed_digit_unpacker_unit_tb: done, errors");
        $finish;
    end

endmodule
